### design/nmeacs_pkg.sv
package nmeacs_pkg;

  // Sentence framing characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;

  // Hex field parsing
  localparam int unsigned HEX_ACC_W = 17;
  localparam logic [HEX_ACC_W-1:0] HEX_LIMIT = 17'h10000;

  // Progress through the checksum field text
  typedef enum logic [2:0] {
    ST_LEAD   = 3'd0,
    ST_ZERO   = 3'd1,
    ST_PREFIX = 3'd2,
    ST_DIGITS = 3'd3,
    ST_TRAIL  = 3'd4,
    ST_BAD    = 3'd5
  } hex_status_t;

  // Hex parser state carried between bytes
  typedef struct packed {
    hex_status_t            status;
    logic [HEX_ACC_W-1:0]   acc;
  } hex_state_t;

endpackage

### design/nmeacs_hex.sv
module nmeacs_hex import nmeacs_pkg::*; (
  input  hex_state_t state_i,
  input  logic [7:0] char_i,
  output hex_state_t state_o
);

  logic                 is_ws;
  logic                 is_digit;
  logic [3:0]           digit;
  logic [HEX_ACC_W+3:0] sum;
  logic [HEX_ACC_W-1:0] acc_add;

  // Classify the byte
  always_comb begin
    is_ws    = (char_i == 8'd32) || (char_i >= 8'd9 && char_i <= 8'd13);
    is_digit = 1'b1;
    digit    = 4'd0;
    if (char_i >= 8'h30 && char_i <= 8'h39) begin
      digit = 4'(char_i - 8'h30);
    end else if (char_i >= 8'h41 && char_i <= 8'h46) begin
      digit = 4'(char_i - 8'h37);
    end else if (char_i >= 8'h61 && char_i <= 8'h66) begin
      digit = 4'(char_i - 8'h57);
    end else begin
      is_digit = 1'b0;
    end
  end

  // Shift in one digit, saturating just past the 16-bit range
  always_comb begin
    sum     = {state_i.acc, 4'd0} + {{HEX_ACC_W{1'b0}}, digit};
    acc_add = (sum > {4'd0, HEX_LIMIT}) ? HEX_LIMIT : sum[HEX_ACC_W-1:0];
  end

  // Advance the field parser by one byte
  always_comb begin
    state_o = state_i;
    case (state_i.status)
      ST_LEAD: begin
        if (is_ws) begin
          state_o.status = ST_LEAD;
        end else if (char_i == 8'h30) begin
          state_o.status = ST_ZERO;
        end else if (is_digit) begin
          state_o.acc    = acc_add;
          state_o.status = ST_DIGITS;
        end else begin
          state_o.status = ST_BAD;
        end
      end
      ST_ZERO, ST_DIGITS: begin
        if (state_i.status == ST_ZERO && (char_i == 8'h78 || char_i == 8'h58)) begin
          state_o.status = ST_PREFIX;
        end else if (is_ws) begin
          state_o.status = ST_TRAIL;
        end else if (is_digit) begin
          state_o.acc    = acc_add;
          state_o.status = ST_DIGITS;
        end else begin
          state_o.status = ST_BAD;
        end
      end
      ST_PREFIX: begin
        if (is_digit) begin
          state_o.acc    = acc_add;
          state_o.status = ST_DIGITS;
        end else begin
          state_o.status = ST_BAD;
        end
      end
      ST_TRAIL: begin
        if (!is_ws) state_o.status = ST_BAD;
      end
      default: state_o.status = ST_BAD;
    endcase
  end

endmodule

### design/nmea_checksum_checker_core.sv
// NMEA 0183 checksum checker. Feed a sentence one byte per request with
// in_last set on its final byte; one result per sentence comes out, carrying
// whether a '*' was seen, whether the received hex field matches the XOR of
// the body, and both checksum bytes. A byte is taken every clock cycle unless
// a final byte waits on a stalled result; a result passes the input register,
// then the result register, and the per-byte hex field update is combinational.
// A stalled result holds only bytes that end a sentence; other bytes keep
// flowing into the running state while the result waits.
module nmea_checksum_checker_core import nmeacs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_character,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_has_checksum,
  output logic       out_checksum_ok,
  output logic [7:0] out_computed_checksum,
  output logic [7:0] out_received_checksum
);

  typedef enum logic [1:0] {
    PH_BODY  = 2'd0,
    PH_FIELD = 2'd1,
    PH_AFTER = 2'd2
  } phase_t;

  // Input register
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_last_r;
  logic       s1_move;

  // Sentence state
  logic       first_r,  first_nxt;
  phase_t     phase_r,  phase_nxt;
  logic [7:0] xor_r,    xor_nxt;
  hex_state_t hex_r,    hex_nxt;
  hex_state_t hex_upd;

  // Result register
  logic       out_valid_r;
  logic       has_r, ok_r;
  logic [7:0] comp_r, rcv_r;
  logic       res_has;
  logic [7:0] res_rcv;

  // Move a byte on unless it ends a sentence and the result slot is full and stalled
  assign s1_move  = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_char_r <= in_character;
      s1_last_r <= in_last;
    end
  end

  nmeacs_hex u_hex (
    .state_i (hex_r),
    .char_i  (s1_char_r),
    .state_o (hex_upd)
  );

  // Update phase, XOR and hex field for the registered byte
  always_comb begin
    first_nxt = 1'b0;
    phase_nxt = phase_r;
    xor_nxt   = xor_r;
    hex_nxt   = hex_r;
    case (phase_r)
      PH_BODY: begin
        if (s1_char_r == CH_STAR) begin
          phase_nxt = PH_FIELD;
        end else if (!first_r && s1_char_r != CH_DOLLAR) begin
          xor_nxt = xor_r ^ s1_char_r;
        end
      end
      PH_FIELD: begin
        if (s1_char_r == CH_STAR) begin
          phase_nxt = PH_AFTER;
        end else begin
          hex_nxt = hex_upd;
        end
      end
      default: ;
    endcase
  end

  // Form the result from the state after this byte
  always_comb begin
    res_has = (phase_nxt != PH_BODY);
    res_rcv = 8'd0;
    if (res_has && (hex_nxt.status == ST_ZERO || hex_nxt.status == ST_DIGITS ||
                    hex_nxt.status == ST_TRAIL) && hex_nxt.acc < HEX_LIMIT) begin
      res_rcv = hex_nxt.acc[7:0];
    end
  end

  // Hold sentence state; drop it back to reset after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
      phase_r <= PH_BODY;
      xor_r   <= 8'd0;
      hex_r   <= '{status: ST_LEAD, acc: '0};
    end else if (s1_move) begin
      if (s1_last_r) begin
        first_r <= 1'b1;
        phase_r <= PH_BODY;
        xor_r   <= 8'd0;
        hex_r   <= '{status: ST_LEAD, acc: '0};
      end else begin
        first_r <= first_nxt;
        phase_r <= phase_nxt;
        xor_r   <= xor_nxt;
        hex_r   <= hex_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_last_r) begin
      has_r  <= res_has;
      ok_r   <= res_has && (res_rcv == xor_nxt);
      comp_r <= xor_nxt;
      rcv_r  <= res_rcv;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_has_checksum      = has_r;
  assign out_checksum_ok       = ok_r;
  assign out_computed_checksum = comp_r;
  assign out_received_checksum = rcv_r;

endmodule

### design/nmeacs_checker.sv
module nmeacs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_character,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_has_checksum,
  input logic       out_checksum_ok,
  input logic [7:0] out_computed_checksum,
  input logic [7:0] out_received_checksum
);

  // Reset empties the result slot
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled request stays offered with the same byte
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=>
      in_valid && $stable(in_character) && $stable(in_last))
    else $error("stalled request changed");

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  // A match implies a separator and equal checksums
  a_ok_means_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_checksum_ok |->
      out_has_checksum && out_received_checksum == out_computed_checksum)
    else $error("match flag without equal checksums");

  // Without a separator nothing is received
  a_no_sep_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_checksum |->
      out_received_checksum == 8'd0 && !out_checksum_ok)
    else $error("received checksum without separator");

endmodule

bind nmea_checksum_checker_core nmeacs_checker u_nmeacs_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_valid),
  .in_stall              (in_stall),
  .in_character          (in_character),
  .in_last               (in_last),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_has_checksum      (out_has_checksum),
  .out_checksum_ok       (out_checksum_ok),
  .out_computed_checksum (out_computed_checksum),
  .out_received_checksum (out_received_checksum)
);

### verif/tb.sv
`timescale 1ns / 100ps

module tb import nmeacs_pkg::*;;

  localparam int RANDOM_ITEMS = 1100;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_AT      = 500;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;

  // Field parsing characters not in the package
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_LX   = 8'h78;
  localparam logic [7:0] CH_UX   = 8'h58;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [4:0] NOT_HEX = 5'd16;

  // Where the sentence stands relative to its '*' separators
  localparam logic [1:0] PH_BODY  = 2'd0;
  localparam logic [1:0] PH_FIELD = 2'd1;
  localparam logic [1:0] PH_AFTER = 2'd2;

  typedef struct packed {
    logic       has_sum;
    logic       sum_ok;
    logic [7:0] computed;
    logic [7:0] received;
  } verdict_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       typed;
    verdict_t   v;
  } row_t;

  localparam verdict_t NO_VERDICT = '0;

  // Directed sentences; the verdict is typed in on each closing byte
  localparam row_t DIRECTED_ROWS [28] = '{
    // single-byte sentence, no separator
    '{8'hFF,     1'b1, 1'b1, '{1'b0, 1'b0, 8'h00, 8'h00}},
    // whitespace between digits spoils the field
    '{CH_DOLLAR, 1'b0, 1'b0, NO_VERDICT},
    '{8'h41,     1'b0, 1'b0, NO_VERDICT},
    '{CH_STAR,   1'b0, 1'b0, NO_VERDICT},
    '{8'h34,     1'b0, 1'b0, NO_VERDICT},
    '{CH_SP,     1'b0, 1'b0, NO_VERDICT},
    '{8'h31,     1'b1, 1'b1, '{1'b1, 1'b0, 8'h41, 8'h00}},
    // byte extremes, '$' skipped, 0x prefix, mixed case, trailing blank
    '{8'h00,     1'b0, 1'b0, NO_VERDICT},
    '{CH_DOLLAR, 1'b0, 1'b0, NO_VERDICT},
    '{8'hFF,     1'b0, 1'b0, NO_VERDICT},
    '{CH_STAR,   1'b0, 1'b0, NO_VERDICT},
    '{CH_ZERO,   1'b0, 1'b0, NO_VERDICT},
    '{CH_LX,     1'b0, 1'b0, NO_VERDICT},
    '{8'h66,     1'b0, 1'b0, NO_VERDICT},
    '{8'h46,     1'b0, 1'b0, NO_VERDICT},
    '{8'h0D,     1'b1, 1'b1, '{1'b1, 1'b1, 8'hFF, 8'hFF}},
    // '*' as first byte, value past 65535, text after a second '*'
    '{CH_STAR,   1'b0, 1'b0, NO_VERDICT},
    '{8'h31,     1'b0, 1'b0, NO_VERDICT},
    '{CH_ZERO,   1'b0, 1'b0, NO_VERDICT},
    '{CH_ZERO,   1'b0, 1'b0, NO_VERDICT},
    '{CH_ZERO,   1'b0, 1'b0, NO_VERDICT},
    '{CH_ZERO,   1'b0, 1'b0, NO_VERDICT},
    '{CH_STAR,   1'b0, 1'b0, NO_VERDICT},
    '{8'h80,     1'b1, 1'b1, '{1'b1, 1'b1, 8'h00, 8'h00}},
    // bare prefix reads as zero
    '{8'h42,     1'b0, 1'b0, NO_VERDICT},
    '{CH_STAR,   1'b0, 1'b0, NO_VERDICT},
    '{CH_ZERO,   1'b0, 1'b0, NO_VERDICT},
    '{CH_UX,     1'b1, 1'b1, '{1'b1, 1'b1, 8'h00, 8'h00}}
  };

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_character;
  logic       in_last;
  logic       out_valid;
  logic       out_stall;
  logic       out_has_checksum;
  logic       out_checksum_ok;
  logic [7:0] out_computed_checksum;
  logic [7:0] out_received_checksum;

  row_t       stim_q [$];
  logic [7:0] sentence_q [$];
  verdict_t   verdicts_due [$];
  int         bytes_taken = 0;
  int         fails = 0;
  int         cycles = 0;

  // Sentence checksum state
  bit                   sn_first  = 1'b1;
  logic [1:0]           sn_phase  = PH_BODY;
  logic [7:0]           sn_xor    = 8'h00;
  logic [HEX_ACC_W-1:0] sn_acc    = '0;
  hex_status_t          sn_status = ST_LEAD;

  nmea_checksum_checker_core dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_character          (in_character),
    .in_last               (in_last),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_has_checksum      (out_has_checksum),
    .out_checksum_ok       (out_checksum_ok),
    .out_computed_checksum (out_computed_checksum),
    .out_received_checksum (out_received_checksum)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SP || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [4:0] digit_of(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h37);
    if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h57);
    return NOT_HEX;
  endfunction

  // Shift in one digit, pinning the value once it passes 16 bits
  function automatic logic [HEX_ACC_W-1:0] acc_digit(logic [HEX_ACC_W-1:0] acc,
                                                     logic [4:0] d);
    logic [HEX_ACC_W+3:0] nxt;
    nxt = {acc, 4'h0} + {{(HEX_ACC_W-1){1'b0}}, d};
    return (nxt > {4'h0, HEX_LIMIT}) ? HEX_LIMIT : nxt[HEX_ACC_W-1:0];
  endfunction

  // Advance the checksum state by one byte; give the verdict on the last one
  task automatic predict_byte(input logic [7:0] c, input logic last,
                              output bit emit, output verdict_t v);
    bit         was_first;
    logic [4:0] d;
    was_first = sn_first;
    sn_first  = 1'b0;
    d         = digit_of(c);
    if (sn_phase == PH_BODY) begin
      if (c == CH_STAR) sn_phase = PH_FIELD;
      else if (!was_first && c != CH_DOLLAR) sn_xor ^= c;
    end else if (sn_phase == PH_FIELD) begin
      if (c == CH_STAR) begin
        sn_phase = PH_AFTER;
      end else begin
        case (sn_status)
          ST_LEAD: begin
            if (is_blank(c)) ;
            else if (c == CH_ZERO) sn_status = ST_ZERO;
            else if (d != NOT_HEX) begin
              sn_acc    = acc_digit(sn_acc, d);
              sn_status = ST_DIGITS;
            end else sn_status = ST_BAD;
          end
          // a lone '0' not followed by x acts as an ordinary digit
          ST_ZERO, ST_DIGITS: begin
            if (sn_status == ST_ZERO && (c == CH_LX || c == CH_UX)) sn_status = ST_PREFIX;
            else if (is_blank(c)) sn_status = ST_TRAIL;
            else if (d != NOT_HEX) begin
              sn_acc    = acc_digit(sn_acc, d);
              sn_status = ST_DIGITS;
            end else sn_status = ST_BAD;
          end
          ST_PREFIX: begin
            if (d != NOT_HEX) begin
              sn_acc    = acc_digit(sn_acc, d);
              sn_status = ST_DIGITS;
            end else sn_status = ST_BAD;
          end
          ST_TRAIL: begin
            if (!is_blank(c)) sn_status = ST_BAD;
          end
          default: sn_status = ST_BAD;
        endcase
      end
    end
    emit = last;
    v    = NO_VERDICT;
    if (last) begin
      v.has_sum  = (sn_phase != PH_BODY);
      v.computed = sn_xor;
      if (v.has_sum && sn_acc < HEX_LIMIT &&
          (sn_status == ST_ZERO || sn_status == ST_DIGITS || sn_status == ST_TRAIL))
        v.received = sn_acc[7:0];
      v.sum_ok = v.has_sum && (v.received == sn_xor);
      // start over for the next sentence
      sn_first  = 1'b1;
      sn_phase  = PH_BODY;
      sn_xor    = 8'h00;
      sn_acc    = '0;
      sn_status = ST_LEAD;
    end
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    if (nib < 4'd10) return CH_ZERO + {4'h0, nib};
    return (($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61) + {4'h0, nib} - 8'd10;
  endfunction

  function automatic logic [7:0] blank_char();
    int r;
    r = $urandom_range(9, 14);
    return (r == 14) ? CH_SP : 8'(r);
  endfunction

  function automatic logic [7:0] body_char();
    logic [7:0] c;
    do begin
      case ($urandom_range(0, 9))
        0:       c = CH_DOLLAR;
        1:       c = 8'($urandom_range(0, 255));
        default: c = 8'($urandom_range(8'h20, 8'h7E));
      endcase
    end while (c == CH_STAR);
    return c;
  endfunction

  task automatic put_pair(logic [7:0] val);
    sentence_q.push_back(hex_char(val[7:4]));
    sentence_q.push_back(hex_char(val[3:0]));
  endtask

  // Build one random sentence: mostly well formed, some raw noise
  task automatic add_sentence();
    logic [7:0] c;
    logic [7:0] sum;
    bit         noise;
    row_t       r;
    sentence_q.delete();
    sum   = 8'h00;
    noise = ($urandom_range(0, 99) < 8);
    if (noise) begin
      repeat ($urandom_range(1, 12)) sentence_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      sentence_q.push_back(($urandom_range(0, 9) != 0) ? CH_DOLLAR : body_char());
      repeat ($urandom_range(0, 15)) begin
        c = body_char();
        sentence_q.push_back(c);
        if (c != CH_DOLLAR) sum ^= c;
      end
      if ($urandom_range(0, 99) < 88) begin
        sentence_q.push_back(CH_STAR);
        case ($urandom_range(0, 15))
          0, 1, 2, 3, 4: put_pair(sum);
          5: begin
            sentence_q.push_back(CH_ZERO);
            sentence_q.push_back(($urandom_range(0, 1) != 0) ? CH_LX : CH_UX);
            put_pair(sum);
          end
          6: begin
            repeat ($urandom_range(1, 2)) sentence_q.push_back(blank_char());
            put_pair(sum);
            repeat ($urandom_range(1, 2)) sentence_q.push_back(blank_char());
          end
          7: put_pair(sum ^ 8'($urandom_range(1, 255)));
          8: ;
          9: repeat ($urandom_range(1, 3)) sentence_q.push_back(blank_char());
          10: begin
            sentence_q.push_back(hex_char(4'($urandom_range(0, 15))));
            sentence_q.push_back(8'($urandom_range(0, 255)));
          end
          11: begin
            sentence_q.push_back(CH_ZERO);
            if ($urandom_range(0, 1) != 0) sentence_q.push_back(blank_char());
          end
          12: begin
            sentence_q.push_back(hex_char(4'($urandom_range(1, 15))));
            repeat ($urandom_range(4, 5))
              sentence_q.push_back(hex_char(4'($urandom_range(0, 15))));
          end
          13: begin
            repeat ($urandom_range(1, 2))
              sentence_q.push_back(hex_char(4'($urandom_range(0, 15))));
            put_pair(sum);
          end
          14: begin
            sentence_q.push_back(hex_char(sum[7:4]));
            sentence_q.push_back(blank_char());
            sentence_q.push_back(hex_char(sum[3:0]));
          end
          default: begin
            sentence_q.push_back(CH_ZERO);
            sentence_q.push_back(CH_UX);
          end
        endcase
        // trailing junk after a second separator
        if ($urandom_range(0, 4) == 0) begin
          sentence_q.push_back(CH_STAR);
          repeat ($urandom_range(0, 4)) sentence_q.push_back(8'($urandom_range(0, 255)));
        end
      end
    end
    foreach (sentence_q[i]) begin
      r.ch    = sentence_q[i];
      r.last  = (i == sentence_q.size() - 1) || (noise && $urandom_range(0, 5) == 0);
      r.typed = 1'b0;
      r.v     = NO_VERDICT;
      stim_q.push_back(r);
    end
  endtask

  // Mostly back-to-back requests, some short gaps, a few long ones
  function automatic int pick_gap(int idx);
    int r;
    if ((idx / 200) % 5 == 2) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Reset, then offer every request in order
  initial begin : drive_requests
    int idx;
    int gap;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_character <= 8'h00;
    in_last      <= 1'b0;
    foreach (DIRECTED_ROWS[i]) stim_q.push_back(DIRECTED_ROWS[i]);
    while (stim_q.size() < $size(DIRECTED_ROWS) + RANDOM_ITEMS) add_sentence();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    idx = 0;
    while (idx < stim_q.size()) begin
      gap = pick_gap(idx);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid     <= 1'b1;
      in_character <= stim_q[idx].ch;
      in_last      <= stim_q[idx].last;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      idx++;
    end
    in_valid <= 1'b0;
    // drain outstanding verdicts, then give the pipeline time to misbehave
    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) $display("nmea_checksum_checker_core test passed");
    else $display("nmea_checksum_checker_core test failed");
    $finish;
  end

  // Stall the result side at random, with one long hold-off to back up the input
  initial begin : drive_out_stall
    bit hold_done;
    int r;
    hold_done = 1'b0;
    forever begin
      if (!hold_done && bytes_taken >= HOLD_AT) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ((cycles / 1500) % 6 == 3) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        out_stall <= (r >= 55);
        if (r < 55) repeat ($urandom_range(1, 8)) @(posedge clk);
        else if (r < 93) repeat ($urandom_range(1, 3)) @(posedge clk);
        else repeat ($urandom_range(15, 60)) @(posedge clk);
      end
    end
  end

  // Predict on every accepted request
  always @(posedge clk) begin : track_requests
    bit       emit;
    verdict_t v;
    if (rst_n && in_valid && !in_stall) begin
      predict_byte(in_character, in_last, emit, v);
      if (stim_q[bytes_taken].typed) v = stim_q[bytes_taken].v;
      if (emit) verdicts_due.push_back(v);
      bytes_taken++;
    end
  end

  // Compare each accepted result with the oldest verdict
  always @(posedge clk) begin : check_results
    verdict_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        $error("result with no sentence pending");
        fails++;
      end else begin
        want = verdicts_due.pop_front();
        if (out_has_checksum !== want.has_sum) begin
          $error("has_checksum: expected %0h, got %0h", want.has_sum, out_has_checksum);
          fails++;
        end
        if (out_checksum_ok !== want.sum_ok) begin
          $error("checksum_ok: expected %0h, got %0h", want.sum_ok, out_checksum_ok);
          fails++;
        end
        if (out_computed_checksum !== want.computed) begin
          $error("computed_checksum: expected %0h, got %0h",
                 want.computed, out_computed_checksum);
          fails++;
        end
        if (out_received_checksum !== want.received) begin
          $error("received_checksum: expected %0h, got %0h",
                 want.received, out_received_checksum);
          fails++;
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("nmea_checksum_checker_core test failed");
      $finish;
    end
  end

endmodule

### nmea_checksum_checker_core.f
design/nmeacs_pkg.sv
design/nmeacs_hex.sv
design/nmea_checksum_checker_core.sv
design/nmeacs_checker.sv
verif/tb.sv
